// ===== hdl/scs_pkg.sv =====
package scs_pkg;

    localparam int FRAC_DEF = 28;
    // Smallest supported fraction width; the fixed widths below hold for it.
    localparam int FRAC_MIN = 16;

    localparam int MW  = 40;              // modulus register width
    localparam int PW  = 64 - FRAC_MIN;   // one scaled F product
    localparam int EW  = PW + 2;          // strain component
    localparam int TW  = EW + 2;          // strain trace
    localparam int OW  = 48;              // stress output width
    localparam int AW  = 128;             // wide accumulator
    localparam int NSYM = 6;              // independent entries of a symmetric tensor

    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = 64 / DIV_BPS;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_SHEAR  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_LAMBDA = 2'd1;

    localparam int SYM_XX = 0;
    localparam int SYM_YY = 3;
    localparam int SYM_ZZ = 5;

    typedef logic signed [31:0]   t_f32;
    typedef t_f32 [8:0]           t_fmat;
    typedef logic signed [EW-1:0] t_e;
    typedef t_e [NSYM-1:0]        t_evec;
    typedef logic signed [TW-1:0] t_tr;
    typedef logic signed [63:0]   t_s64;
    typedef t_s64 [NSYM-1:0]      t_svec;
    typedef t_s64 [8:0]           t_tmat;
    typedef logic [63:0]          t_u64;
    typedef logic signed [65:0]   t_ppe;
    typedef t_ppe [3:0]           t_pp;
    typedef logic signed [AW-1:0] t_acc;

    typedef struct packed {
        logic bad;
        logic clip;
    } t_flags;

    typedef struct packed {
        logic clip;
        t_s64 v;
    } t_sat;

    typedef struct packed {
        t_fmat  f;
        t_f32   jac;
        t_flags fl;
        t_evec  e;
        t_tr    tr;
    } t_strain;

    typedef struct packed {
        t_fmat  f;
        t_f32   jac;
        t_flags fl;
        t_svec  s;
    } t_pk2;

    typedef struct packed {
        t_f32   jac;
        t_flags fl;
        t_svec  u;
    } t_cau;

    typedef struct packed {
        t_flags          fl;
        logic [NSYM-1:0] neg;
        t_u64 [NSYM-1:0] q;
    } t_quo;

    // Row and column of the n-th upper-triangle entry: xx xy xz yy yz zz.
    function automatic int sym_r(input int n);
        unique case (n)
            0, 1, 2: return 0;
            3, 4:    return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int sym_c(input int n);
        unique case (n)
            0:       return 0;
            1, 3:    return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int sym(input int i, input int j);
        int a;
        int b;
        a = (i < j) ? i : j;
        b = (i < j) ? j : i;
        unique case (a)
            0:       return b;
            1:       return b + 2;
            default: return 5;
        endcase
    endfunction

    function automatic logic is_diag(input int n);
        return (n == SYM_XX) || (n == SYM_YY) || (n == SYM_ZZ);
    endfunction

    // Four 33x33 partial products of a 64x64 signed product.
    function automatic t_pp mul_pp(input t_s64 a, input t_s64 b);
        logic signed [32:0] al;
        logic signed [32:0] ah;
        logic signed [32:0] bl;
        logic signed [32:0] bh;
        t_pp p;
        al = $signed({1'b0, a[31:0]});
        ah = $signed({a[63], a[63:32]});
        bl = $signed({1'b0, b[31:0]});
        bh = $signed({b[63], b[63:32]});
        p[0] = al * bl;
        p[1] = al * bh;
        p[2] = ah * bl;
        p[3] = ah * bh;
        return p;
    endfunction

    function automatic t_acc pp_sum(input t_pp p);
        return t_acc'(p[0]) + (t_acc'(p[1]) <<< 32) + (t_acc'(p[2]) <<< 32)
             + (t_acc'(p[3]) <<< 64);
    endfunction

    function automatic t_sat clip64(input t_acc a);
        t_sat r;
        if (a[AW-1:63] == '0 || a[AW-1:63] == '1) begin
            r.clip = 1'b0;
            r.v    = a[63:0];
        end else begin
            r.clip = 1'b1;
            r.v    = a[AW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hdl/scs_strain.sv =====
module scs_strain import scs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_fmat   i_f,
    input  t_f32    i_jac,
    output logic    o_valid,
    input  logic    i_ready,
    output t_strain o_data
);

    localparam int NST = 4;
    localparam t_e ONE_Q = t_e'(1) << FRAC_BITS;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST:0]   en;

    assign en[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = ~r_v[k] | en[k+1];
    end
    assign n_v = {r_v[NST-2:0], i_valid};

    t_fmat r_f0, r_f1, r_f2, r_f3;
    t_f32  r_jac0, r_jac1, r_jac2, r_jac3;
    logic  r_bad0, r_bad1, r_bad2, r_bad3;
    logic signed [PW-1:0] r_p1 [18];
    logic signed [PW-1:0] n_p1 [18];
    t_evec r_e2, n_e2, r_e3;
    t_tr   r_tr3, n_tr3;

    // Scaled products F[k][i]*F[k][j] for the upper triangle of F^T F.
    always_comb begin
        t_s64 prod;
        for (int n = 0; n < NSYM; n++) begin
            for (int k = 0; k < 3; k++) begin
                prod = r_f0[3*k + sym_r(n)] * r_f0[3*k + sym_c(n)];
                n_p1[3*n + k] = PW'(prod >>> FRAC_BITS);
            end
        end
    end

    always_comb begin
        t_e c;
        for (int n = 0; n < NSYM; n++) begin
            c = t_e'(r_p1[3*n]) + t_e'(r_p1[3*n + 1]) + t_e'(r_p1[3*n + 2]);
            if (is_diag(n)) begin
                c = c - ONE_Q;
            end
            n_e2[n] = c >>> 1;
        end
    end

    assign n_tr3 = t_tr'(r_e2[SYM_XX]) + t_tr'(r_e2[SYM_YY]) + t_tr'(r_e2[SYM_ZZ]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_f0   <= i_f;
            r_jac0 <= i_jac;
            r_bad0 <= (i_jac <= 32'sd0);
        end
        if (en[1]) begin
            r_f1   <= r_f0;
            r_jac1 <= r_jac0;
            r_bad1 <= r_bad0;
            r_p1   <= n_p1;
        end
        if (en[2]) begin
            r_f2   <= r_f1;
            r_jac2 <= r_jac1;
            r_bad2 <= r_bad1;
            r_e2   <= n_e2;
        end
        if (en[3]) begin
            r_f3   <= r_f2;
            r_jac3 <= r_jac2;
            r_bad3 <= r_bad2;
            r_e3   <= r_e2;
            r_tr3  <= n_tr3;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    always_comb begin
        o_data.f       = r_f3;
        o_data.jac     = r_jac3;
        o_data.fl.bad  = r_bad3;
        o_data.fl.clip = 1'b0;
        o_data.e       = r_e3;
        o_data.tr      = r_tr3;
    end

endmodule

// ===== hdl/scs_pk2.sv =====
module scs_pk2 import scs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_strain       i_data,
    input  logic [MW-1:0] i_mu,
    input  logic [MW-1:0] i_lam,
    output logic          o_valid,
    input  logic          i_ready,
    output t_pk2          o_data
);

    localparam int NST = 3;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST:0]   en;

    assign en[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = ~r_v[k] | en[k+1];
    end
    assign n_v = {r_v[NST-2:0], i_valid};

    t_fmat  r_f0, r_f1, r_f2;
    t_f32   r_jac0, r_jac1, r_jac2;
    t_flags r_fl0, r_fl1, r_fl2;
    t_pp    r_m0 [NSYM];
    t_pp    n_m0 [NSYM];
    t_pp    r_pl0, n_pl0;
    t_acc   r_w1 [NSYM];
    t_acc   n_w1 [NSYM];
    t_svec  r_s2, n_s2;
    logic   n_clip2;

    // 2*mu times each strain entry, lambda times the trace.
    always_comb begin
        t_s64 mu2;
        t_s64 lam;
        mu2 = {23'd0, i_mu, 1'b0};
        lam = {24'd0, i_lam};
        for (int n = 0; n < NSYM; n++) begin
            n_m0[n] = mul_pp(mu2, t_s64'(i_data.e[n]));
        end
        n_pl0 = mul_pp(lam, t_s64'(i_data.tr));
    end

    always_comb begin
        for (int n = 0; n < NSYM; n++) begin
            n_w1[n] = pp_sum(r_m0[n]) + (is_diag(n) ? pp_sum(r_pl0) : '0);
        end
    end

    always_comb begin
        t_sat st;
        n_clip2 = r_fl1.clip;
        for (int n = 0; n < NSYM; n++) begin
            st      = clip64(r_w1[n]);
            n_s2[n] = st.v;
            n_clip2 = n_clip2 | st.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_f0   <= i_data.f;
            r_jac0 <= i_data.jac;
            r_fl0  <= i_data.fl;
            r_m0   <= n_m0;
            r_pl0  <= n_pl0;
        end
        if (en[1]) begin
            r_f1   <= r_f0;
            r_jac1 <= r_jac0;
            r_fl1  <= r_fl0;
            r_w1   <= n_w1;
        end
        if (en[2]) begin
            r_f2        <= r_f1;
            r_jac2      <= r_jac1;
            r_fl2.bad   <= r_fl1.bad;
            r_fl2.clip  <= n_clip2;
            r_s2        <= n_s2;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    always_comb begin
        o_data.f   = r_f2;
        o_data.jac = r_jac2;
        o_data.fl  = r_fl2;
        o_data.s   = r_s2;
    end

endmodule

// ===== hdl/scs_push.sv =====
module scs_push import scs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_pk2 i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_cau o_data
);

    localparam int NST = 6;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST:0]   en;

    assign en[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = ~r_v[k] | en[k+1];
    end
    assign n_v = {r_v[NST-2:0], i_valid};

    t_fmat  r_f0, r_f1, r_f2;
    t_f32   r_jac0, r_jac1, r_jac2, r_jac3, r_jac4, r_jac5;
    t_flags r_fl0, r_fl1, r_fl2, r_fl3, r_fl4, r_fl5;
    t_pp    r_pa0 [27];
    t_pp    n_pa0 [27];
    t_acc   r_aa1 [9];
    t_acc   n_aa1 [9];
    t_tmat  r_t2, n_t2;
    logic   n_clip2;
    t_pp    r_pb3 [18];
    t_pp    n_pb3 [18];
    t_acc   r_ab4 [NSYM];
    t_acc   n_ab4 [NSYM];
    t_svec  r_u5, n_u5;
    logic   n_clip5;

    // T = F S: partial products of F[i][k] * S[k][j].
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    n_pa0[(3*i + j)*3 + k] = mul_pp(t_s64'(i_data.f[3*i + k]),
                                                    i_data.s[sym(k, j)]);
                end
            end
        end
    end

    always_comb begin
        for (int m = 0; m < 9; m++) begin
            n_aa1[m] = pp_sum(r_pa0[3*m]) + pp_sum(r_pa0[3*m + 1])
                     + pp_sum(r_pa0[3*m + 2]);
        end
    end

    always_comb begin
        t_sat st;
        n_clip2 = r_fl1.clip;
        for (int m = 0; m < 9; m++) begin
            st      = clip64(r_aa1[m] >>> FRAC_BITS);
            n_t2[m] = st.v;
            n_clip2 = n_clip2 | st.clip;
        end
    end

    // U = T F^T, upper triangle only.
    always_comb begin
        for (int n = 0; n < NSYM; n++) begin
            for (int k = 0; k < 3; k++) begin
                n_pb3[3*n + k] = mul_pp(r_t2[3*sym_r(n) + k],
                                        t_s64'(r_f2[3*sym_c(n) + k]));
            end
        end
    end

    always_comb begin
        for (int n = 0; n < NSYM; n++) begin
            n_ab4[n] = pp_sum(r_pb3[3*n]) + pp_sum(r_pb3[3*n + 1])
                     + pp_sum(r_pb3[3*n + 2]);
        end
    end

    always_comb begin
        t_sat st;
        n_clip5 = r_fl4.clip;
        for (int n = 0; n < NSYM; n++) begin
            st      = clip64(r_ab4[n] >>> FRAC_BITS);
            n_u5[n] = st.v;
            n_clip5 = n_clip5 | st.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_f0   <= i_data.f;
            r_jac0 <= i_data.jac;
            r_fl0  <= i_data.fl;
            r_pa0  <= n_pa0;
        end
        if (en[1]) begin
            r_f1   <= r_f0;
            r_jac1 <= r_jac0;
            r_fl1  <= r_fl0;
            r_aa1  <= n_aa1;
        end
        if (en[2]) begin
            r_f2       <= r_f1;
            r_jac2     <= r_jac1;
            r_fl2.bad  <= r_fl1.bad;
            r_fl2.clip <= n_clip2;
            r_t2       <= n_t2;
        end
        if (en[3]) begin
            r_jac3 <= r_jac2;
            r_fl3  <= r_fl2;
            r_pb3  <= n_pb3;
        end
        if (en[4]) begin
            r_jac4 <= r_jac3;
            r_fl4  <= r_fl3;
            r_ab4  <= n_ab4;
        end
        if (en[5]) begin
            r_jac5     <= r_jac4;
            r_fl5.bad  <= r_fl4.bad;
            r_fl5.clip <= n_clip5;
            r_u5       <= n_u5;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    always_comb begin
        o_data.jac = r_jac5;
        o_data.fl  = r_fl5;
        o_data.u   = r_u5;
    end

endmodule

// ===== hdl/scs_div.sv =====
module scs_div import scs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cau i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_quo o_data
);

    // One stage takes magnitudes, then each stage retires DIV_BPS quotient bits.
    localparam int NST = DIV_STAGES + 1;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST:0]   en;

    assign en[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = ~r_v[k] | en[k+1];
    end
    assign n_v = {r_v[NST-2:0], i_valid};

    logic [31:0]     r_rem [NST][NSYM];
    logic [31:0]     n_rem [NST][NSYM];
    t_u64            r_num [NST][NSYM];
    t_u64            n_num [NST][NSYM];
    logic [30:0]     r_d   [NST];
    logic [30:0]     n_d   [NST];
    t_flags          r_fl  [NST];
    t_flags          n_fl  [NST];
    logic [NSYM-1:0] r_neg [NST];
    logic [NSYM-1:0] n_neg [NST];

    always_comb begin
        logic [31:0] rm;
        t_u64        nm;
        for (int n = 0; n < NSYM; n++) begin
            n_num[0][n] = i_data.u[n][63] ? t_u64'(-i_data.u[n]) : t_u64'(i_data.u[n]);
            n_rem[0][n] = '0;
            n_neg[0][n] = i_data.u[n][63];
        end
        n_d[0]  = i_data.jac[30:0];
        n_fl[0] = i_data.fl;
        for (int st = 1; st < NST; st++) begin
            n_d[st]   = r_d[st-1];
            n_fl[st]  = r_fl[st-1];
            n_neg[st] = r_neg[st-1];
            for (int n = 0; n < NSYM; n++) begin
                rm = r_rem[st-1][n];
                nm = r_num[st-1][n];
                // Restoring steps; quotient bits shift in as dividend bits leave.
                for (int b = 0; b < DIV_BPS; b++) begin
                    rm = {rm[30:0], nm[63]};
                    nm = {nm[62:0], 1'b0};
                    if (rm >= {1'b0, r_d[st-1]}) begin
                        rm    = rm - {1'b0, r_d[st-1]};
                        nm[0] = 1'b1;
                    end
                end
                n_rem[st][n] = rm;
                n_num[st][n] = nm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int st = 0; st < NST; st++) begin
            if (en[st]) begin
                r_rem[st] <= n_rem[st];
                r_num[st] <= n_num[st];
                r_d[st]   <= n_d[st];
                r_fl[st]  <= n_fl[st];
                r_neg[st] <= n_neg[st];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];

    always_comb begin
        o_data.fl  = r_fl[NST-1];
        o_data.neg = r_neg[NST-1];
        for (int n = 0; n < NSYM; n++) begin
            o_data.q[n] = r_num[NST-1][n];
        end
    end

endmodule

// ===== hdl/stvk_cauchy_stress.sv =====
// St Venant-Kirchhoff Cauchy stress, one mesh cell per item.
// Input channel (i_valid / o_ready): the nine components of the deformation
// gradient F, row by row, and its Jacobian J, all signed fixed point with
// FRAC_BITS fraction bits. Output channel (o_valid / i_ready): the six upper
// components of the Cauchy stress in pascals, saturated to 48 bits, with the
// flags o_bad_volume (J not positive, stresses forced to zero) and
// o_saturated (some intermediate or final value was clipped).
// The moduli are written through the plain write port i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no item is in flight, as the block does not enforce it.
// On its way to o_valid, an accepted item enters the first of four strain
// stages at the accepting edge, then passes three stages for the second
// Piola-Kirchhoff stress, six for the two tensor products and seventeen for
// the pipelined divider by J, plus the output register.
// Throughput is one item per cycle while the receiver takes results; every
// stage is a pipeline register with its own valid bit.
// When the receiver stalls, the results hold in the output register while
// empty stages further up keep filling, so o_ready falls only when the
// whole pipeline is full. Reset empties the pipeline and clears both moduli.
module stvk_cauchy_stress import scs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IW-1:0]     i_cfg_idx,
    input  logic [MW-1:0]         i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_f_xx,
    input  logic signed [31:0]    i_f_xy,
    input  logic signed [31:0]    i_f_xz,
    input  logic signed [31:0]    i_f_yx,
    input  logic signed [31:0]    i_f_yy,
    input  logic signed [31:0]    i_f_yz,
    input  logic signed [31:0]    i_f_zx,
    input  logic signed [31:0]    i_f_zy,
    input  logic signed [31:0]    i_f_zz,
    input  logic signed [31:0]    i_jacobian,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [OW-1:0]  o_stress_xx,
    output logic signed [OW-1:0]  o_stress_xy,
    output logic signed [OW-1:0]  o_stress_xz,
    output logic signed [OW-1:0]  o_stress_yy,
    output logic signed [OW-1:0]  o_stress_yz,
    output logic signed [OW-1:0]  o_stress_zz,
    output logic                  o_bad_volume,
    output logic                  o_saturated
);

    // Quotient magnitude limits of the 48-bit signed output.
    localparam t_u64 POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
    localparam t_u64 NEG_LIM = 64'h0000_8000_0000_0000;

    logic [MW-1:0] r_mu;
    logic [MW-1:0] r_lam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu  <= '0;
            r_lam <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHEAR:  r_mu  <= i_cfg_data;
                REG_LAMBDA: r_lam <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_fmat f_in;

    always_comb begin
        f_in[0] = i_f_xx;
        f_in[1] = i_f_xy;
        f_in[2] = i_f_xz;
        f_in[3] = i_f_yx;
        f_in[4] = i_f_yy;
        f_in[5] = i_f_yz;
        f_in[6] = i_f_zx;
        f_in[7] = i_f_zy;
        f_in[8] = i_f_zz;
    end

    logic    strn_valid, strn_ready;
    t_strain strn_data;
    logic    pk2_valid, pk2_ready;
    t_pk2    pk2_data;
    logic    push_valid, push_ready;
    t_cau    push_data;
    logic    div_valid, div_ready;
    t_quo    div_data;

    // Strain E = (F^T F - I) / 2 and its trace.
    scs_strain #(.FRAC_BITS(FRAC_BITS)) u_strain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_f     (f_in),
        .i_jac   (i_jacobian),
        .o_valid (strn_valid),
        .i_ready (strn_ready),
        .o_data  (strn_data)
    );

    // S = 2 mu E + lambda tr(E) I.
    scs_pk2 u_pk2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (strn_valid),
        .o_ready (strn_ready),
        .i_data  (strn_data),
        .i_mu    (r_mu),
        .i_lam   (r_lam),
        .o_valid (pk2_valid),
        .i_ready (pk2_ready),
        .o_data  (pk2_data)
    );

    // F S F^T.
    scs_push #(.FRAC_BITS(FRAC_BITS)) u_push (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pk2_valid),
        .o_ready (pk2_ready),
        .i_data  (pk2_data),
        .o_valid (push_valid),
        .i_ready (push_ready),
        .o_data  (push_data)
    );

    // Division by J, truncated toward zero on magnitudes.
    scs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_valid),
        .o_ready (push_ready),
        .i_data  (push_data),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_data  (div_data)
    );

    // Output register: restore the sign, clip to 48 bits, and force a bad
    // volume to zero stress with no saturation.
    logic                       r_ov;
    logic signed [OW-1:0]       r_st [NSYM];
    logic signed [OW-1:0]       n_st [NSYM];
    logic                       r_bad, r_sat;
    logic                       n_sat;
    logic                       en_o;

    assign en_o      = ~r_ov | i_ready;
    assign div_ready = en_o;

    always_comb begin
        t_u64 negq;
        n_sat = div_data.fl.clip;
        for (int n = 0; n < NSYM; n++) begin
            negq = -div_data.q[n];
            if (div_data.neg[n]) begin
                if (div_data.q[n] > NEG_LIM) begin
                    n_st[n] = {1'b1, {(OW-1){1'b0}}};
                    n_sat   = 1'b1;
                end else begin
                    n_st[n] = negq[OW-1:0];
                end
            end else begin
                if (div_data.q[n] > POS_LIM) begin
                    n_st[n] = {1'b0, {(OW-1){1'b1}}};
                    n_sat   = 1'b1;
                end else begin
                    n_st[n] = div_data.q[n][OW-1:0];
                end
            end
        end
        if (div_data.fl.bad) begin
            for (int n = 0; n < NSYM; n++) begin
                n_st[n] = '0;
            end
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_st  <= n_st;
            r_bad <= div_data.fl.bad;
            r_sat <= n_sat;
        end
    end

    assign o_valid      = r_ov;
    assign o_stress_xx  = r_st[0];
    assign o_stress_xy  = r_st[1];
    assign o_stress_xz  = r_st[2];
    assign o_stress_yy  = r_st[3];
    assign o_stress_yz  = r_st[4];
    assign o_stress_zz  = r_st[5];
    assign o_bad_volume = r_bad;
    assign o_saturated  = r_sat;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_volume |-> !o_saturated && o_stress_xx == '0
            && o_stress_yy == '0 && o_stress_zz == '0)
        else $error("bad volume item carries nonzero stress or saturation");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while the pipeline can still advance");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result presented right after reset");
`endif

endmodule
